### design/swu_pkg.sv
// shared constants, types and character table for the word to utf-8 converter
`timescale 1ns / 1ps

package swu_pkg;

  localparam int CharW    = 7;
  localparam int NumChars = 5;
  localparam int WordW    = 36;
  localparam int ByteW    = 8;
  localparam int CpW      = 14;
  localparam int LeftW    = $clog2(NumChars + 1);

  localparam logic [CharW-1:0] ChNul = 7'o000;
  localparam logic [CharW-1:0] ChLf  = 7'o012;
  localparam logic [CharW-1:0] ChCr  = 7'o015;

  // one output step requested by the sequencer
  typedef struct packed {
    logic             push;
    logic [ByteW-1:0] data;
    logic             finish;
    logic             bad;
  } swu_emit_t;

  function automatic logic [CpW-1:0] to_unicode(input logic [CharW-1:0] ch);
    logic [CpW-1:0] cp;
    case (ch)
      7'o001:  cp = 14'o20623;
      7'o002:  cp = 14'o01661;
      7'o003:  cp = 14'o01662;
      7'o004:  cp = 14'o21047;
      7'o005:  cp = 14'o00254;
      7'o006:  cp = 14'o01665;
      7'o007:  cp = 14'o01700;
      7'o010:  cp = 14'o01673;
      7'o016:  cp = 14'o21036;
      7'o017:  cp = 14'o21002;
      7'o020:  cp = 14'o21202;
      7'o021:  cp = 14'o21203;
      7'o022:  cp = 14'o21051;
      7'o023:  cp = 14'o21052;
      7'o024:  cp = 14'o21000;
      7'o025:  cp = 14'o21003;
      7'o026:  cp = 14'o21227;
      7'o027:  cp = 14'o20624;
      7'o030:  cp = 14'o00137;
      7'o031:  cp = 14'o20622;
      7'o032:  cp = 14'o00176;
      7'o033:  cp = 14'o21140;
      7'o034:  cp = 14'o21144;
      7'o035:  cp = 14'o21145;
      7'o036:  cp = 14'o21141;
      7'o037:  cp = 14'o21050;
      7'o136:  cp = 14'o20621;
      7'o137:  cp = 14'o20620;
      7'o176:  cp = 14'o00175;
      default: cp = {{(CpW-CharW){1'b0}}, ch};
    endcase
    return cp;
  endfunction

endpackage

### design/swu_stream_if.sv
// valid/ready stream interfaces for the text words and the output bytes
`timescale 1ns / 1ps

interface swu_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [35:0] text_word;

  modport source (output valid, output kind, output text_word, input ready);
  modport sink (input valid, input kind, input text_word, output ready);
endinterface

interface swu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       last;
  logic       bad_word;

  modport source (output valid, output out_byte, output has_byte, output last,
                  output bad_word, input ready);
  modport sink (input valid, input out_byte, input has_byte, input last,
                input bad_word, output ready);
endinterface

### design/swu_char_shift.sv
// character shift register, one 7-bit character per step from the high end
`timescale 1ns / 1ps

module swu_char_shift
  import swu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic             flush_i,
  input  logic [WordW-1:0] word_i,
  input  logic             shift_i,
  output logic [CharW-1:0] ch_o,
  output logic             last_ch_o,
  output logic             busy_o
);

  localparam int ChainW = CharW * NumChars;

  logic [ChainW-1:0] chars_q, chars_d;
  logic [LeftW-1:0]  left_q, left_d;

  always_comb begin
    chars_d = chars_q;
    left_d  = left_q;
    if (load_i) begin
      // a flush runs as a single nul character
      chars_d = flush_i ? '0 : word_i[WordW-1 -: ChainW];
      left_d  = flush_i ? LeftW'(1) : LeftW'(NumChars);
    end else if (shift_i && left_q != '0) begin
      chars_d = {chars_q[ChainW-CharW-1:0], {CharW{1'b0}}};
      left_d  = left_q - LeftW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    chars_q <= chars_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else begin
      left_q <= left_d;
    end
  end

  assign ch_o      = chars_q[ChainW-1 -: CharW];
  assign last_ch_o = (left_q == LeftW'(1));
  assign busy_o    = (left_q != '0);

endmodule

### design/swu_char_enc.sv
// byte list of one character: held carriage return (a lone line feed for cr lf), then its utf-8 bytes
`timescale 1ns / 1ps

module swu_char_enc
  import swu_pkg::*;
(
  input  logic [CharW-1:0] ch_i,
  input  logic             pending_i,
  input  logic [1:0]       idx_i,
  output logic [ByteW-1:0] byte_o,
  output logic [2:0]       cnt_o
);

  logic [CpW-1:0]   cp;
  logic [ByteW-1:0] body [3];
  logic [ByteW-1:0] pre_byte;
  logic [1:0]       body_len;
  logic [1:0]       body_idx;

  always_comb begin
    cp       = to_unicode(ch_i);
    pre_byte = (ch_i == ChLf) ? ByteW'(ChLf) : ByteW'(ChCr);
    body[0]  = '0;
    body[1]  = '0;
    body[2]  = '0;
    body_len = 2'd0;
    if (ch_i == ChNul || ch_i == ChCr) begin
      body_len = 2'd0;
    end else if (ch_i == ChLf) begin
      body_len = pending_i ? 2'd0 : 2'd1;
      body[0]  = ByteW'(ChLf);
    end else if (cp >= CpW'(14'h800)) begin
      body_len = 2'd3;
      body[0]  = {4'hE, 2'b00, cp[13:12]};
      body[1]  = {2'b10, cp[11:6]};
      body[2]  = {2'b10, cp[5:0]};
    end else if (cp >= CpW'(14'h80)) begin
      body_len = 2'd2;
      body[0]  = {3'b110, cp[10:6]};
      body[1]  = {2'b10, cp[5:0]};
    end else begin
      body_len = 2'd1;
      body[0]  = cp[7:0];
    end

    body_idx = pending_i ? (idx_i - 2'd1) : idx_i;
    if (pending_i && idx_i == 2'd0) begin
      byte_o = pre_byte;
    end else if (body_idx == 2'd3) begin
      byte_o = '0;
    end else begin
      byte_o = body[body_idx];
    end
    cnt_o = {1'b0, body_len} + {2'b00, pending_i};
  end

endmodule

### design/swu_byte_out.sv
// one-byte hold stage and output register that mark the last byte of an item
`timescale 1ns / 1ps

module swu_byte_out
  import swu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  swu_emit_t emit_i,
  output logic      slot_free_o,
  swu_out_if.source out_o
);

  logic             held_valid_q, held_valid_d;
  logic [ByteW-1:0] held_q, held_d;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic             has_q, has_d;
  logic             last_q, last_d;
  logic             bad_q, bad_d;

  assign slot_free_o = !out_valid_q || out_o.ready;

  always_comb begin
    held_valid_d = held_valid_q;
    held_d       = held_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    byte_d       = byte_q;
    has_d        = has_q;
    last_d       = last_q;
    bad_d        = bad_q;
    if (emit_i.bad) begin
      out_valid_d = 1'b1;
      byte_d      = '0;
      has_d       = 1'b0;
      last_d      = 1'b1;
      bad_d       = 1'b1;
    end else if (emit_i.push) begin
      if (held_valid_q) begin
        out_valid_d = 1'b1;
        byte_d      = held_q;
        has_d       = 1'b1;
        last_d      = 1'b0;
        bad_d       = 1'b0;
      end
      held_valid_d = 1'b1;
      held_d       = emit_i.data;
    end else if (emit_i.finish) begin
      // empty result when the item sent nothing
      out_valid_d  = 1'b1;
      byte_d       = held_valid_q ? held_q : '0;
      has_d        = held_valid_q;
      last_d       = 1'b1;
      bad_d        = 1'b0;
      held_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      held_valid_q <= held_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
    byte_q <= byte_d;
    has_q  <= has_d;
    last_q <= last_d;
    bad_q  <= bad_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = byte_q;
  assign out_o.has_byte = has_q;
  assign out_o.last     = last_q;
  assign out_o.bad_word = bad_q;

endmodule

### design/sail_word_to_utf8_text_top.sv
// top level of the 36-bit text word to utf-8 byte stream converter
`timescale 1ns / 1ps

// Converts 36-bit words of five 7-bit characters into UTF-8 bytes, one byte
// per output transaction, with last set on the final result of each input
// transaction; an item that sends no byte gives one empty result. A word is
// accepted, then the bytes of each character are sent in turn, then the item
// is closed; no new word is taken until the item is closed. A bad word (bit 0
// set) gives a lone error result, and a flush sends out a held carriage return
// and closes the item. A carriage return is held across words until the next
// character or a flush decides it.

module sail_word_to_utf8_text_top
  import swu_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  swu_in_if.sink  src_i,
  swu_out_if.source dst_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic             pending_q, pending_d;
  logic [1:0]       idx_q, idx_d;
  logic             slot_free;
  logic             in_fire;
  logic             bad_in;
  logic             load;
  logic             shift;
  logic [CharW-1:0] ch;
  logic             last_ch;
  logic             sh_busy;
  logic [ByteW-1:0] enc_byte;
  logic [2:0]       enc_cnt;
  swu_emit_t        emit;

  assign src_i.ready = (state_q == StIdle) && slot_free;
  assign in_fire     = src_i.valid && src_i.ready;
  assign bad_in      = in_fire && !src_i.kind && src_i.text_word[0];
  assign load        = in_fire && !bad_in;

  swu_char_shift u_shift (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load),
    .flush_i   (src_i.kind),
    .word_i    (src_i.text_word),
    .shift_i   (shift),
    .ch_o      (ch),
    .last_ch_o (last_ch),
    .busy_o    (sh_busy)
  );

  swu_char_enc u_enc (
    .ch_i      (ch),
    .pending_i (pending_q),
    .idx_i     (idx_q),
    .byte_o    (enc_byte),
    .cnt_o     (enc_cnt)
  );

  always_comb begin
    state_d     = state_q;
    pending_d   = pending_q;
    idx_d       = idx_q;
    shift       = 1'b0;
    emit        = '0;
    emit.data   = enc_byte;
    case (state_q)
      StIdle: begin
        emit.bad = bad_in;
        if (load) begin
          idx_d   = 2'd0;
          state_d = StRun;
        end
      end
      StRun: begin
        if (slot_free) begin
          emit.push = (enc_cnt != 3'd0);
          if (enc_cnt == 3'd0 || {1'b0, idx_q} == enc_cnt - 3'd1) begin
            shift     = 1'b1;
            pending_d = (ch == ChCr);
            idx_d     = 2'd0;
            if (last_ch) begin
              state_d = StFin;
            end
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end
      end
      StFin: begin
        if (slot_free) begin
          emit.finish = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      pending_q <= 1'b0;
      idx_q     <= 2'd0;
    end else begin
      state_q   <= state_d;
      pending_q <= pending_d;
      idx_q     <= idx_d;
    end
  end

  swu_byte_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .slot_free_o (slot_free),
    .out_o       (dst_o)
  );

`ifndef ASSERT_OFF
  a_run_has_chars: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRun |-> sh_busy)
    else $error("sequencer running with no characters left");

  a_fin_no_chars: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StFin |-> !sh_busy)
    else $error("item closed with characters left");

  a_bad_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bad_in |=> dst_o.valid && dst_o.bad_word && dst_o.last && !dst_o.has_byte)
    else $error("bad word did not give a lone error result");

  a_bad_keeps_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bad_in |=> pending_q == $past(pending_q))
    else $error("bad word changed the held carriage return");

  a_byte_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRun && enc_cnt != 3'd0 |-> {1'b0, idx_q} < enc_cnt)
    else $error("byte index past the character's byte count");
`endif

endmodule
